FILE: rtl/core/running_lcm_of_periods_macros.svh
// Assertion helpers shared by the RTL of the running lcm block.
// Each macro takes a label, the clock, the active-low reset, a trigger
// condition, an expected condition and a message.
`ifndef RUNNING_LCM_OF_PERIODS_MACROS_SVH
`define RUNNING_LCM_OF_PERIODS_MACROS_SVH

`ifndef SYNTHESIS
// Expected condition holds in the same cycle as the trigger.
`define RLCM_ASSERT_NOW(lbl, clk, rstn, trig, expect_c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (expect_c)) \
        else $error(msg);
// Expected condition holds in the cycle after the trigger.
`define RLCM_ASSERT_NXT(lbl, clk, rstn, trig, expect_c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (expect_c)) \
        else $error(msg);
`else
`define RLCM_ASSERT_NOW(lbl, clk, rstn, trig, expect_c, msg)
`define RLCM_ASSERT_NXT(lbl, clk, rstn, trig, expect_c, msg)
`endif

`endif

FILE: rtl/core/rlcm_pkg.sv
package rlcm_pkg;

    // Fixed field widths of the request and response channels.
    localparam int PERIOD_W = 16;
    localparam int LCM_W    = 48;
    localparam int LIMIT_W  = 48;

    localparam logic [LIMIT_W-1:0] SYNC_LIMIT_RESET = 48'd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/core/rlcm_if.sv
interface rlcm_req_if
    import rlcm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period;
    logic                last_in_set;

    modport source (output valid, output period, output last_in_set, input ready);
    modport sink   (input valid, input period, input last_in_set, output ready);
endinterface

interface rlcm_rsp_if
    import rlcm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LCM_W-1:0] partial_lcm;
    logic             within_limit;
    logic             overflowed;
    logic             set_done;

    modport source (output valid, output partial_lcm, output within_limit,
                    output overflowed, output set_done, input ready);
    modport sink   (input valid, input partial_lcm, input within_limit,
                    input overflowed, input set_done, output ready);
endinterface

FILE: rtl/core/running_lcm_of_periods.sv
// Channel | Dir | Payload                                           | Handshake
// req     | in  | period, last_in_set                               | valid / ready
// rsp     | out | partial_lcm, within_limit, overflowed, set_done   | valid / ready
// cfg     | in  | cfg_data (sync_limit)                             | cfg_we, no ready
//
// A request runs the binary gcd, the divide and the multiply in turn, all on
// the single shared add/subtract unit. A request that arrives after the set
// has overflowed skips them and goes straight to the final write.
// Reset puts the accumulator at 1, clears the overflow flag and loads 50 into
// sync_limit. A stalled response sits in the output register; the next request
// is taken and computed meanwhile and waits only at its final write.

`include "running_lcm_of_periods_macros.svh"

module running_lcm_of_periods
    import rlcm_pkg::*;
#(
    parameter int PERIOD_BITS = 16,
    parameter int ACC_BITS    = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    rlcm_req_if.sink           req,
    rlcm_rsp_if.source         rsp,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data
);

    // Width of the gcd operands: must hold both the accumulator and a period.
    localparam int GW     = (ACC_BITS > PERIOD_BITS) ? ACC_BITS : PERIOD_BITS;
    localparam int PROD_W = ACC_BITS + PERIOD_BITS;
    // The shared unit is one bit wider than any operand, so its top bit is
    // the borrow of a subtraction.
    localparam int WIDE   = ((GW > PROD_W) ? GW : PROD_W) + 1;
    localparam int CW     = $clog2(GW + 1);
    localparam int KW     = $clog2(PERIOD_BITS + 1);
    localparam int CMP_W  = (ACC_BITS > LIMIT_W) ? ACC_BITS : LIMIT_W;

    localparam logic [ACC_BITS-1:0]       ACC_MAX = '1;
    localparam logic [ACC_BITS+LCM_W-1:0] SAT_EXT = {LCM_W'(0), ACC_MAX};

    // Control state.
    state_t                state_reg, state_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                  sticky_reg, sticky_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // Datapath registers.
    logic [PERIOD_BITS-1:0] p_reg, p_next;
    logic                   last_reg, last_next;
    logic [GW-1:0]          u_reg, u_next;
    logic [GW-1:0]          v_reg, v_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [PERIOD_BITS-1:0] g_reg, g_next;
    logic [PERIOD_BITS-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0]      mcand_reg, mcand_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [LCM_W-1:0]       lcm_out_reg, lcm_out_next;
    logic                   within_reg, within_next;
    logic                   ovf_out_reg, ovf_out_next;
    logic                   done_out_reg, done_out_next;

    // Shared add/subtract unit.
    logic [WIDE-1:0] alu_a;
    logic [WIDE-1:0] alu_b;
    logic            alu_sub;
    logic [WIDE-1:0] alu_sum;
    logic            alu_neg;

    // Helpers.
    logic [PERIOD_W+PERIOD_BITS-1:0] p_ext;
    logic [PERIOD_BITS-1:0]          p_in;
    logic [GW-1:0]                   g_shift;
    logic [PERIOD_BITS:0]            rem_shift;
    logic                            ovf_new;
    logic [ACC_BITS-1:0]             lcm_new;
    logic [ACC_BITS+LCM_W-1:0]       lcm_ext;
    logic                            within_new;
    logic                            req_fire;
    logic                            out_free;
    logic                            result_fire;

    assign req_fire    = req.valid && req.ready;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign result_fire = (state_reg == ST_DONE) && out_free;

    // Only the low PERIOD_BITS bits of the period take part; zero counts as one.
    assign p_ext = {PERIOD_BITS'(0), req.period};
    assign p_in  = (p_ext[PERIOD_BITS-1:0] == '0) ? PERIOD_BITS'(1)
                                                   : p_ext[PERIOD_BITS-1:0];

    // The gcd is the common odd part restored by the common power of two.
    assign g_shift   = v_reg << k_reg;
    assign rem_shift = {rem_reg, u_reg[ACC_BITS-1]};

    // Once the set has overflowed the accumulator stays saturated.
    assign ovf_new    = sticky_reg || (prod_reg[PROD_W-1:ACC_BITS] != '0);
    assign lcm_new    = ovf_new ? ACC_MAX : prod_reg[ACC_BITS-1:0];
    assign lcm_ext    = {LCM_W'(0), lcm_new};
    assign within_new = last_reg && !ovf_new &&
                        (CMP_W'(lcm_new) <= CMP_W'(limit_reg));

    // Operand selection for the shared unit, by phase.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_GCD:
            begin
                alu_a   = WIDE'(u_reg);
                alu_b   = WIDE'(v_reg);
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_a   = WIDE'(rem_shift);
                alu_b   = WIDE'(g_reg);
                alu_sub = 1'b1;
            end
            ST_MUL:
            begin
                alu_a   = WIDE'(prod_reg);
                alu_b   = WIDE'(mcand_reg);
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + WIDE'(alu_sub);
    assign alu_neg = alu_sum[WIDE-1];

    // Sequencer: binary gcd, restoring divide of the accumulator by the gcd,
    // then shift-and-add multiply of the quotient by the period.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sticky_next    = sticky_reg;
        limit_next     = cfg_we ? cfg_data : limit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        p_next         = p_reg;
        last_next      = last_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        rem_next       = rem_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        lcm_out_next   = lcm_out_reg;
        within_next    = within_reg;
        ovf_out_next   = ovf_out_reg;
        done_out_next  = done_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    p_next    = p_in;
                    last_next = req.last_in_set;
                    u_next    = GW'(acc_reg);
                    v_next    = GW'(p_in);
                    k_next    = '0;
                    if (sticky_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_GCD;
                    end
                end
            end

            ST_GCD:
            begin
                if (u_reg == v_reg)
                begin
                    g_next     = g_shift[PERIOD_BITS-1:0];
                    u_next     = GW'(acc_reg);
                    rem_next   = '0;
                    cnt_next   = CW'(ACC_BITS);
                    state_next = ST_DIV;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (alu_neg)
                begin
                    // Keep the larger odd value in u so the next step subtracts.
                    u_next = v_reg;
                    v_next = u_reg;
                end
                else
                begin
                    u_next = alu_sum[GW-1:0];
                end
            end

            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    mcand_next = PROD_W'(u_reg[ACC_BITS-1:0]);
                    prod_next  = '0;
                    cnt_next   = CW'(PERIOD_BITS);
                    state_next = ST_MUL;
                end
                else
                begin
                    if (!alu_neg)
                    begin
                        rem_next = alu_sum[PERIOD_BITS-1:0];
                    end
                    else
                    begin
                        rem_next = rem_shift[PERIOD_BITS-1:0];
                    end
                    u_next   = GW'({u_reg[ACC_BITS-2:0], !alu_neg});
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (p_reg[0])
                    begin
                        prod_next = alu_sum[PROD_W-1:0];
                    end
                    mcand_next = mcand_reg << 1;
                    p_next     = p_reg >> 1;
                    cnt_next   = cnt_reg - CW'(1);
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    lcm_out_next   = lcm_ext[LCM_W-1:0];
                    within_next    = within_new;
                    ovf_out_next   = ovf_new;
                    done_out_next  = last_reg;
                    if (last_reg)
                    begin
                        acc_next    = ACC_BITS'(1);
                        sticky_next = 1'b0;
                    end
                    else
                    begin
                        acc_next    = lcm_new;
                        sticky_next = ovf_new;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= ACC_BITS'(1);
            sticky_reg    <= 1'b0;
            limit_reg     <= SYNC_LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            sticky_reg    <= sticky_next;
            limit_reg     <= limit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        last_reg     <= last_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        k_reg        <= k_next;
        g_reg        <= g_next;
        rem_reg      <= rem_next;
        mcand_reg    <= mcand_next;
        prod_reg     <= prod_next;
        cnt_reg      <= cnt_next;
        lcm_out_reg  <= lcm_out_next;
        within_reg   <= within_next;
        ovf_out_reg  <= ovf_out_next;
        done_out_reg <= done_out_next;
    end

    // Requests are taken only between computations.
    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.partial_lcm  = lcm_out_reg;
    assign rsp.within_limit = within_reg;
    assign rsp.overflowed   = ovf_out_reg;
    assign rsp.set_done     = done_out_reg;

    `RLCM_ASSERT_NXT(a_req_starts_work, clk, rst_n, req_fire, state_reg != ST_IDLE, "request accepted but sequencer stayed idle")
    `RLCM_ASSERT_NOW(a_gcd_nonzero, clk, rst_n, state_reg == ST_GCD, u_reg != '0 && v_reg != '0, "gcd operand reached zero")
    `RLCM_ASSERT_NOW(a_div_by_nonzero, clk, rst_n, state_reg == ST_DIV, g_reg != '0, "divide by zero gcd")
    `RLCM_ASSERT_NXT(a_set_end_clears, clk, rst_n, result_fire && last_reg, acc_reg == ACC_BITS'(1) && !sticky_reg, "accumulator not cleared at end of set")
    `RLCM_ASSERT_NOW(a_ovf_saturates, clk, rst_n, rsp.valid && rsp.overflowed, rsp.partial_lcm == SAT_EXT[LCM_W-1:0] && !rsp.within_limit, "overflowed result not saturated")

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import rlcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The run stops here no matter what. The slowest legal request runs a long
    // binary gcd, divide and multiply. With sender gaps, receiver stalls and the
    // one long hold, the whole run stays far below this figure.
    localparam int unsigned CYCLE_LIMIT     = 600_000;
    localparam int          ITEMS_PER_PHASE = 80;
    localparam int          PHASE_COUNT     = 5;
    localparam int          LONG_HOLD       = 400;
    // Extra cycles after the last result, so that any stray response shows up.
    localparam int          TAIL_CYCLES     = 300;
    localparam bit [63:0]   ACC_ALL_ONES    = 64'h0000_FFFF_FFFF_FFFF;

    // One response of the block, as the checker compares it.
    typedef struct packed {
        logic [LCM_W-1:0] partial_lcm;
        logic             within_limit;
        logic             overflowed;
        logic             set_done;
    } lcm_result_t;

    // One row of the directed table. When has_value is set, the response is
    // compared with the hand-written value. Otherwise the predictor supplies
    // the expected response.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                last_in_set;
        bit                  has_value;
        lcm_result_t         value;
    } period_row_t;

    // Flavors of random sets. Each one pushes the accumulator toward a
    // different corner of its behavior.
    typedef enum int {
        SET_SMALL,
        SET_WIDE,
        SET_ZEROES,
        SET_HUGE,
        SET_BITS
    } set_kind_t;

    localparam int DIRECTED_ROWS = 25;
    localparam logic [LCM_W-1:0] LCM_SATURATED = 48'hFFFF_FFFF_FFFF;

    // The directed part runs with the reset value of sync_limit, which is 50.
    period_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // Sets of one request, straight after reset: the result is the period.
        '{16'd1,     1'b1, 1'b1, '{48'd1,     1'b1, 1'b0, 1'b1}},
        // A zero period counts as 1.
        '{16'd0,     1'b1, 1'b1, '{48'd1,     1'b1, 1'b0, 1'b1}},
        '{16'hFFFF,  1'b1, 1'b1, '{48'd65535, 1'b0, 1'b0, 1'b1}},
        // The limit itself is still within it. One above is not.
        '{16'd50,    1'b1, 1'b1, '{48'd50,    1'b1, 1'b0, 1'b1}},
        '{16'd51,    1'b1, 1'b1, '{48'd51,    1'b0, 1'b0, 1'b1}},
        // Periods that share factors.
        '{16'd4,     1'b0, 1'b0, '0},
        '{16'd6,     1'b1, 1'b0, '0},
        // A zero period in the middle of a set.
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd7,     1'b1, 1'b0, '0},
        // Four large primes. The fourth one overflows the accumulator. The
        // periods after that are not folded in, and the set ends saturated.
        '{16'd65521, 1'b0, 1'b0, '0},
        '{16'd65519, 1'b0, 1'b0, '0},
        '{16'd65497, 1'b0, 1'b0, '0},
        '{16'd65479, 1'b0, 1'b0, '0},
        '{16'd2,     1'b0, 1'b0, '0},
        '{16'd0,     1'b1, 1'b1, '{LCM_SATURATED, 1'b0, 1'b1, 1'b1}},
        // The accumulator must come back to 1 after the saturated set.
        '{16'd32768, 1'b0, 1'b0, '0},
        '{16'd16384, 1'b0, 1'b0, '0},
        '{16'hFFFF,  1'b1, 1'b0, '0},
        '{16'd3,     1'b0, 1'b0, '0},
        '{16'd5,     1'b0, 1'b0, '0},
        '{16'd2,     1'b1, 1'b0, '0},
        '{16'd10,    1'b0, 1'b0, '0},
        '{16'd25,    1'b1, 1'b0, '0},
        '{16'hFFFF,  1'b0, 1'b0, '0},
        '{16'hFFFF,  1'b1, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LIMIT_W-1:0] cfg_data;

    rlcm_req_if req_ch ();
    rlcm_rsp_if rsp_ch ();

    running_lcm_of_periods dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // The predictor's copy of the block's state and of its one register.
    bit [LCM_W-1:0]   model_acc;
    bit               model_overflow;
    bit [LIMIT_W-1:0] model_limit;

    // Expected responses, oldest first. The checker pops one for each
    // response that the block delivers.
    lcm_result_t pending_lcms [$];
    int unsigned lcm_mismatches;

    // The sender's burst bookkeeping, and the request for one long receiver
    // hold-off.
    int burst_left;
    bit hold_request;

    // Clock: 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Folds one period into the predicted accumulator and returns the
    // response that the block must produce for it. The gcd uses the plain
    // remainder loop. The block may find it another way, but the value is
    // the same.
    function automatic lcm_result_t fold_period(input logic [PERIOD_W-1:0] period,
                                                input logic last_in_set);
        bit [63:0] p;
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] r;
        bit [63:0] q;
        lcm_result_t res;

        p = (period == '0) ? 64'd1 : 64'(period);
        // Once the set has overflowed, the accumulator stays saturated until
        // the set ends.
        if (!model_overflow)
        begin
            a = 64'(model_acc);
            b = p;
            while (b != 0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            q = 64'(model_acc) / a;
            if (q > ACC_ALL_ONES / p)
            begin
                model_overflow = 1'b1;
                model_acc      = '1;
            end
            else
            begin
                model_acc = LCM_W'(q * p);
            end
        end

        res.partial_lcm  = model_acc;
        res.overflowed   = model_overflow;
        res.set_done     = last_in_set;
        res.within_limit = last_in_set && !model_overflow && (model_acc <= model_limit);

        if (last_in_set)
        begin
            model_acc      = LCM_W'(1);
            model_overflow = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period(input set_kind_t kind);
        int unsigned bit_pos;

        bit_pos = $urandom_range(0, PERIOD_W - 1);
        case (kind)
            SET_SMALL:  return PERIOD_W'($urandom_range(1, 12));
            SET_WIDE:   return PERIOD_W'($urandom_range(1, 16'hFFFF));
            SET_ZEROES: return ($urandom_range(0, 1) == 0) ? '0
                                                           : PERIOD_W'($urandom_range(1, 20));
            SET_HUGE:   return PERIOD_W'($urandom_range(40000, 16'hFFFF));
            default:
            begin
                // Single bits, and all ones with a single bit cleared.
                if ($urandom_range(0, 1) == 0)
                    return PERIOD_W'(1) << bit_pos;
                return ~(PERIOD_W'(1) << bit_pos);
            end
        endcase
    endfunction

    // Offers one request and holds it until the block takes it. It is called
    // at a falling edge and returns at a falling edge. The expected response
    // is queued at the rising edge that accepts the request, so the
    // predictor sees the requests in the block's own order.
    task automatic offer_period(input logic [PERIOD_W-1:0] period, input logic last_in_set,
                                input bit has_value, input lcm_result_t value);
        lcm_result_t predicted;

        req_ch.valid       <= 1'b1;
        req_ch.period      <= period;
        req_ch.last_in_set <= last_in_set;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = fold_period(period, last_in_set);
        pending_lcms.push_back(has_value ? value : predicted);
        @(negedge clk);

        // The sender works in bursts. Between two bursts, valid drops for a
        // random number of cycles. Now and then a long burst runs back to back.
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 9);
        end
    endtask

    // Stops offering requests and waits until every expected response has
    // come back. Each request yields exactly one response, so the block is
    // idle after that.
    task automatic drain_lcms();
        req_ch.valid <= 1'b0;
        while (pending_lcms.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    // The block takes the new limit at the rising edge where cfg_we is high.
    task automatic write_sync_limit(input logic [LIMIT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        model_limit = value;
    endtask

    // Receiver. It changes ready at falling edges, following a pattern of
    // its own: calm stretches where it always takes responses, and choppy
    // stretches where ready is low about a third of the time. Once, on request, it
    // holds ready low for a long stretch. The block then fills up with one
    // response in its output register and the next one computed, and it
    // must stall its input while the sender keeps offering.
    initial
    begin : receiver
        int  seg_left;
        bit  calm;
        bit  hold_served;

        seg_left    = 0;
        calm        = 1'b0;
        hold_served = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                rsp_ch.ready <= 1'b0;
                for (int i = 1; i < LONG_HOLD; i++) @(negedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    calm     = ($urandom_range(0, 3) == 0);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
            end
        end
    end

    // Checker. At each rising edge where a response is taken, it compares
    // the response field by field with the oldest expected response. A
    // response that arrives while nothing is expected is also a failure.
    always @(posedge clk)
    begin : lcm_check
        lcm_result_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_lcms.size() == 0)
            begin
                lcm_mismatches++;
                if (lcm_mismatches <= 10)
                    $display("unexpected response: lcm=%0d within=%0b overflow=%0b done=%0b",
                             rsp_ch.partial_lcm, rsp_ch.within_limit,
                             rsp_ch.overflowed, rsp_ch.set_done);
            end
            else
            begin
                want = pending_lcms.pop_front();
                if (rsp_ch.partial_lcm !== want.partial_lcm
                    || rsp_ch.within_limit !== want.within_limit
                    || rsp_ch.overflowed !== want.overflowed
                    || rsp_ch.set_done !== want.set_done)
                begin
                    lcm_mismatches++;
                    // Each pair reads expected/actual.
                    if (lcm_mismatches <= 10)
                        $display("exp/act lcm %0d/%0d within %0b/%0b ovf %0b/%0b done %0b/%0b",
                                 want.partial_lcm, rsp_ch.partial_lcm,
                                 want.within_limit, rsp_ch.within_limit,
                                 want.overflowed, rsp_ch.overflowed,
                                 want.set_done, rsp_ch.set_done);
                end
            end
        end
    end

    // Watchdog. A run that hangs, for example on a lost response, ends here.
    initial
    begin : watchdog
        int unsigned cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int               sent;
        int               set_len;
        set_kind_t        kind;
        logic [LIMIT_W-1:0] limit;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.period      = '0;
        req_ch.last_in_set = 1'b0;
        cfg_we             = 1'b0;
        cfg_data           = '0;
        model_acc          = LCM_W'(1);
        model_overflow     = 1'b0;
        model_limit        = SYNC_LIMIT_RESET;
        lcm_mismatches     = 0;
        burst_left         = 0;
        hold_request       = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with the limit left at its reset value.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_period(directed_rows[i].period, directed_rows[i].last_in_set,
                         directed_rows[i].has_value, directed_rows[i].value);
        drain_lcms();

        // Random part. Each phase first writes a new limit while the block is
        // idle: zero, all ones, a random full-width value, a small value near
        // typical lcms, and the reset value again. Then it sends whole sets
        // of random content. The second phase also asks for the long
        // receiver hold-off.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       limit = '0;
                1:       limit = '1;
                2:       limit = LIMIT_W'({$urandom, $urandom});
                3:       limit = LIMIT_W'($urandom_range(1, 5000));
                default: limit = SYNC_LIMIT_RESET;
            endcase
            write_sync_limit(limit);
            if (phase == 1)
                hold_request = 1'b1;

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: kind = SET_SMALL;
                    4, 5:       kind = SET_WIDE;
                    6:          kind = SET_ZEROES;
                    7, 8:       kind = SET_HUGE;
                    default:    kind = SET_BITS;
                endcase
                // Sets of large periods run longer, so that they overflow and
                // then go on in the saturated state.
                set_len = $urandom_range(1, (kind == SET_HUGE) ? 7 : 5);
                for (int k = 0; k < set_len; k++)
                    offer_period(pick_period(kind), k == set_len - 1, 1'b0, '0);
                sent += set_len;
            end
            drain_lcms();
        end

        repeat (TAIL_CYCLES) @(negedge clk);

        if (lcm_mismatches == 0 && pending_lcms.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rlcm_pkg.sv
rtl/core/rlcm_if.sv
rtl/core/running_lcm_of_periods.sv
bench/tb_top.sv
